@@ hdl/ael_pkg.sv @@
// shared types and constants for the arithmetic expression lexer
// no dependencies; imported by every lexer module
package ael_pkg;

  // default width of a decoded number value
  localparam int unsigned VALUE_BITS = 31;

  // entries in the queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;

  // character codes that the front recognizes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  // token kinds as they leave the block
  typedef enum logic [2:0] {
    KIND_NUMBER = 3'd0,
    KIND_PLUS   = 3'd1,
    KIND_MINUS  = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_END    = 3'd5
  } token_kind_e;

  // tokens caused by one input transfer, in output order: number, operator, end
  typedef struct packed {
    logic        num_v;
    logic        num_sat;
    logic        op_v;
    token_kind_e op_kind;
    logic        end_v;
  } tok_ctrl_t;

endpackage

@@ hdl/arith_expression_lexer_top.sv @@
// arithmetic expression lexer, top level: front, record queue, back
// the first token of an item passes through the record queue and then the output register
// throughput: one input byte per cycle while each byte yields at most one token
// and the output is ready; the back emits one token per cycle while not stalled,
// so the record queue absorbs items that yield two or three tokens
// reset: asynchronous, clears the number state, the queue and the output valid flag
module arith_expression_lexer_top #(
  parameter int unsigned ValueBits = ael_pkg::VALUE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] char_byte
  input  logic                              s_axis_tuser_i,  // [0] char_present
  input  logic                              s_axis_tlast_i,  // text_end
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [ValueBits-1:0] number_value, [ValueBits] value_saturated, zero pad above
  output logic [((ValueBits + 8) / 8)*8-1:0] m_axis_tdata_o,
  output logic [2:0]                        m_axis_tuser_o,  // [2:0] token_kind
  output logic                              m_axis_tlast_o   // run_last
);
  import ael_pkg::*;

  localparam int unsigned CtrlW  = $bits(tok_ctrl_t);
  localparam int unsigned RecW   = CtrlW + ValueBits;
  localparam int unsigned OutW   = ((ValueBits + 8) / 8) * 8;

  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  tok_ctrl_t            front_ctrl;
  logic [ValueBits-1:0] front_value;
  logic [RecW-1:0]      q_rdata;
  tok_ctrl_t            head_ctrl;
  logic [ValueBits-1:0] head_value;
  token_kind_e          tok_kind;
  logic [ValueBits-1:0] tok_value;
  logic                 tok_sat;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && !q_full;

  ael_front #(.ValueBits(ValueBits)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_byte_i    (s_axis_tdata_i),
    .char_present_i (s_axis_tuser_i),
    .text_end_i     (s_axis_tlast_i),
    .push_o         (push),
    .rec_ctrl_o     (front_ctrl),
    .rec_value_o    (front_value)
  );

  ael_queue #(.DataW(RecW), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_ctrl, front_value}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // split the head record
  assign head_ctrl  = tok_ctrl_t'(q_rdata[RecW-1:ValueBits]);
  assign head_value = q_rdata[ValueBits-1:0];

  ael_back #(.ValueBits(ValueBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!q_empty),
    .rec_ctrl_i  (head_ctrl),
    .rec_value_i (head_value),
    .pop_o       (pop),
    .tok_valid_o (m_axis_tvalid_o),
    .tok_ready_i (m_axis_tready_i),
    .tok_kind_o  (tok_kind),
    .tok_value_o (tok_value),
    .tok_sat_o   (tok_sat),
    .tok_last_o  (m_axis_tlast_o)
  );

  // output packing
  assign m_axis_tdata_o = OutW'({tok_sat, tok_value});
  assign m_axis_tuser_o = tok_kind;

endmodule

@@ hdl/ael_front.sv @@
// lexer front: classifies input bytes, accumulates digits, builds token records
// depends on ael_pkg
module ael_front #(
  parameter int unsigned ValueBits = ael_pkg::VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            char_byte_i,
  input  logic                  char_present_i,
  input  logic                  text_end_i,
  output logic                  push_o,
  output ael_pkg::tok_ctrl_t    rec_ctrl_o,
  output logic [ValueBits-1:0]  rec_value_o
);
  import ael_pkg::*;

  localparam int unsigned ProdW = ValueBits + 4;
  localparam logic [ValueBits-1:0] ValueMax = {ValueBits{1'b1}};

  logic                 in_number_q, in_number_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic                 ovf_q, ovf_d;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [ProdW-1:0]     acc_ext;
  logic [ProdW-1:0]     prod;
  logic                 prod_ovf;
  logic [ValueBits-1:0] acc_next;
  logic                 ovf_next;
  logic                 flush_mid;
  logic                 flush_end;
  tok_ctrl_t            ctrl;

  // digit classification and value*10+digit with saturation
  always_comb begin
    is_digit = char_present_i && (char_byte_i inside {[CHAR_ZERO:CHAR_NINE]});
    digit    = 4'(char_byte_i - CHAR_ZERO);
    acc_ext  = ProdW'(acc_q);
    prod     = (acc_ext << 3) + (acc_ext << 1) + ProdW'(digit);
    prod_ovf = |prod[ProdW-1:ValueBits];
    acc_next = prod_ovf ? ValueMax : prod[ValueBits-1:0];
    ovf_next = ovf_q | prod_ovf;
  end

  // token record for this transfer
  always_comb begin
    flush_mid = char_present_i && !is_digit && in_number_q;
    flush_end = text_end_i && (is_digit || (!char_present_i && in_number_q));

    ctrl         = '0;
    ctrl.op_kind = KIND_PLUS;
    ctrl.num_v   = flush_mid || flush_end;
    ctrl.num_sat = is_digit ? ovf_next : ovf_q;
    ctrl.end_v   = text_end_i;
    if (char_present_i) begin
      case (char_byte_i)
        CHAR_PLUS:  begin ctrl.op_v = 1'b1; ctrl.op_kind = KIND_PLUS;  end
        CHAR_MINUS: begin ctrl.op_v = 1'b1; ctrl.op_kind = KIND_MINUS; end
        CHAR_STAR:  begin ctrl.op_v = 1'b1; ctrl.op_kind = KIND_MUL;   end
        CHAR_SLASH: begin ctrl.op_v = 1'b1; ctrl.op_kind = KIND_DIV;   end
        default:    ctrl.op_v = 1'b0;
      endcase
    end
    rec_ctrl_o  = ctrl;
    rec_value_o = is_digit ? acc_next : acc_q;
    push_o      = accept_i && (ctrl.num_v || ctrl.op_v || ctrl.end_v);
  end

  // number state update
  always_comb begin
    in_number_d = in_number_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    if (accept_i) begin
      if (text_end_i || (char_present_i && !is_digit)) begin
        in_number_d = 1'b0;
        acc_d       = '0;
        ovf_d       = 1'b0;
      end else if (is_digit) begin
        in_number_d = 1'b1;
        acc_d       = acc_next;
        ovf_d       = ovf_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      in_number_q <= in_number_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
    end
  end

endmodule

@@ hdl/ael_queue.sv @@
// small fifo of token records between the lexer front and back
// depends on ael_pkg for the default depth
module ael_queue #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = ael_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             pop_i,
  output logic [DataW-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import ael_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/ael_back.sv @@
// lexer back: walks the head token record and emits one token per transfer
// depends on ael_pkg
module ael_back #(
  parameter int unsigned ValueBits = ael_pkg::VALUE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rec_valid_i,
  input  ael_pkg::tok_ctrl_t       rec_ctrl_i,
  input  logic [ValueBits-1:0]     rec_value_i,
  output logic                     pop_o,
  output logic                     tok_valid_o,
  input  logic                     tok_ready_i,
  output ael_pkg::token_kind_e     tok_kind_o,
  output logic [ValueBits-1:0]     tok_value_o,
  output logic                     tok_sat_o,
  output logic                     tok_last_o
);
  import ael_pkg::*;

  logic                 num_done_q, num_done_d;
  logic                 op_done_q, op_done_d;
  logic                 valid_q, valid_d;
  token_kind_e          kind_q, kind_d;
  logic [ValueBits-1:0] value_q, value_d;
  logic                 sat_q, sat_d;
  logic                 last_q, last_d;

  logic slot_free;
  logic load;
  logic num_pend;
  logic op_pend;

  assign slot_free = !valid_q || tok_ready_i;
  assign load      = slot_free && rec_valid_i;
  assign num_pend  = rec_ctrl_i.num_v && !num_done_q;
  assign op_pend   = rec_ctrl_i.op_v && !op_done_q;

  // pick the next token of the head record
  always_comb begin
    num_done_d = num_done_q;
    op_done_d  = op_done_q;
    valid_d    = valid_q && !tok_ready_i;
    kind_d     = kind_q;
    value_d    = value_q;
    sat_d      = sat_q;
    last_d     = last_q;
    pop_o      = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      value_d = '0;
      sat_d   = 1'b0;
      if (num_pend) begin
        kind_d     = KIND_NUMBER;
        value_d    = rec_value_i;
        sat_d      = rec_ctrl_i.num_sat;
        last_d     = !rec_ctrl_i.op_v && !rec_ctrl_i.end_v;
        num_done_d = 1'b1;
      end else if (op_pend) begin
        kind_d    = rec_ctrl_i.op_kind;
        last_d    = !rec_ctrl_i.end_v;
        op_done_d = 1'b1;
      end else begin
        kind_d = KIND_END;
        last_d = 1'b1;
      end
      // record finished: release it and start fresh on the next one
      if (last_d) begin
        pop_o      = 1'b1;
        num_done_d = 1'b0;
        op_done_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_done_q <= 1'b0;
      op_done_q  <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      num_done_q <= num_done_d;
      op_done_q  <= op_done_d;
      valid_q    <= valid_d;
    end
  end

  // output payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    sat_q   <= sat_d;
    last_q  <= last_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_kind_o  = kind_q;
  assign tok_value_o = value_q;
  assign tok_sat_o   = sat_q;
  assign tok_last_o  = last_q;

endmodule

@@ bench/tb_arith_expression_lexer_top.sv @@
// testbench for arith_expression_lexer_top: directed table, then random expressions
// with random stalls on both streams; tokens checked against an in-bench lexer
// depends on ael_pkg and the lexer rtl only
module tb_arith_expression_lexer_top;
  import ael_pkg::*;

  localparam int unsigned VB     = VALUE_BITS;
  localparam int unsigned DATA_W = ((VB + 8) / 8) * 8;
  localparam logic [63:0] VALUE_MAX = (64'd1 << VB) - 64'd1;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned QUIET_TAIL   = 60;
  localparam int unsigned NDIR         = 27;

  // one input character plus an optional typed-in expectation
  typedef struct packed {
    logic [7:0]      ch;
    logic            present;
    logic            stop;
    logic            typed;
    logic            has_token;
    token_kind_e     kind;
    logic [VB-1:0]   value;
    logic            sat;
  } char_item_t;

  // one expected output token
  typedef struct packed {
    token_kind_e     kind;
    logic [VB-1:0]   value;
    logic            sat;
    logic            last;
  } token_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i = 8'h00;
  logic              s_axis_tuser_i = 1'b0;
  logic              s_axis_tlast_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata_o;
  logic [2:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;

  // lexer state as predicted
  logic        lex_in_number = 1'b0;
  logic [63:0] lex_acc = 64'd0;
  logic        lex_ovf = 1'b0;

  token_t      pending_tokens [$];
  char_item_t  char_items [$];
  int unsigned mismatch_count = 0;
  logic        quiet = 1'b0;
  token_t      want;

  // directed rows: operators, junk bytes, bare markers, digit bounds, saturation
  char_item_t dir_rows [NDIR] = '{
    '{CHAR_PLUS,  1'b1, 1'b0, 1'b1, 1'b1, KIND_PLUS,   0, 1'b0},
    '{CHAR_MINUS, 1'b1, 1'b0, 1'b1, 1'b1, KIND_MINUS,  0, 1'b0},
    '{CHAR_STAR,  1'b1, 1'b0, 1'b1, 1'b1, KIND_MUL,    0, 1'b0},
    '{CHAR_SLASH, 1'b1, 1'b0, 1'b1, 1'b1, KIND_DIV,    0, 1'b0},
    '{8'h00,      1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{8'hff,      1'b0, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{8'h00,      1'b0, 1'b1, 1'b1, 1'b1, KIND_END,    0, 1'b0},
    '{CHAR_ZERO,  1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{8'hff,      1'b1, 1'b0, 1'b1, 1'b1, KIND_NUMBER, 0, 1'b0},
    '{8'h80,      1'b1, 1'b1, 1'b1, 1'b1, KIND_END,    0, 1'b0},
    '{"2",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"1",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"4",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"7",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"4",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"8",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"3",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"6",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"4",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{CHAR_NINE,  1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{CHAR_PLUS,  1'b1, 1'b1, 1'b0, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"7",        1'b1, 1'b1, 1'b0, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"5",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{CHAR_NINE,  1'b0, 1'b1, 1'b0, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{"1",        1'b1, 1'b0, 1'b1, 1'b0, KIND_NUMBER, 0, 1'b0},
    '{8'h3a,      1'b1, 1'b0, 1'b1, 1'b1, KIND_NUMBER, 1, 1'b0},
    '{" ",        1'b1, 1'b1, 1'b1, 1'b1, KIND_END,    0, 1'b0}
  };

  arith_expression_lexer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] exp_val);
    $display("mismatch %s: got %0h, expected %0h at %0t", field, got, exp_val, $realtime);
    mismatch_count++;
  endtask

  // token predictor
  task automatic emit_token(input token_kind_e kind, input logic [VB-1:0] value,
                            input logic sat);
    token_t tok;
    tok.kind  = kind;
    tok.value = value;
    tok.sat   = sat;
    tok.last  = 1'b0;
    pending_tokens.push_back(tok);
  endtask

  task automatic mark_last();
    token_t tok;
    tok = pending_tokens.pop_back();
    tok.last = 1'b1;
    pending_tokens.push_back(tok);
  endtask

  task automatic flush_number();
    if (lex_in_number) begin
      emit_token(KIND_NUMBER, lex_acc[VB-1:0], lex_ovf);
      lex_in_number = 1'b0;
      lex_acc = 64'd0;
      lex_ovf = 1'b0;
    end
  endtask

  task automatic lex_char(input logic [7:0] ch, input logic present, input logic stop);
    int unsigned base;
    logic [63:0] digit;
    base = pending_tokens.size();
    if (present) begin
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        digit = 64'(ch) - 64'(CHAR_ZERO);
        // clamp at the top of the value range
        if (lex_acc > (VALUE_MAX - digit) / 64'd10) begin
          lex_acc = VALUE_MAX;
          lex_ovf = 1'b1;
        end else begin
          lex_acc = lex_acc * 64'd10 + digit;
        end
        lex_in_number = 1'b1;
      end else begin
        flush_number();
        case (ch)
          CHAR_PLUS:  emit_token(KIND_PLUS, '0, 1'b0);
          CHAR_MINUS: emit_token(KIND_MINUS, '0, 1'b0);
          CHAR_STAR:  emit_token(KIND_MUL, '0, 1'b0);
          CHAR_SLASH: emit_token(KIND_DIV, '0, 1'b0);
          default: ;
        endcase
      end
    end
    if (stop) begin
      flush_number();
      emit_token(KIND_END, '0, 1'b0);
      lex_in_number = 1'b0;
      lex_acc = 64'd0;
      lex_ovf = 1'b0;
    end
    if (pending_tokens.size() > base) mark_last();
  endtask

  // random expression text
  task automatic add_char(input logic [7:0] ch, input logic present, input logic stop);
    char_item_t it;
    it = '0;
    it.ch = ch;
    it.present = present;
    it.stop = stop;
    char_items.push_back(it);
  endtask

  task automatic set_stop_on_last();
    char_item_t it;
    it = char_items.pop_back();
    it.stop = 1'b1;
    char_items.push_back(it);
  endtask

  function automatic logic [7:0] op_char(input int unsigned k);
    case (k)
      0: op_char = CHAR_PLUS;
      1: op_char = CHAR_MINUS;
      2: op_char = CHAR_STAR;
      default: op_char = CHAR_SLASH;
    endcase
  endfunction

  task automatic add_blank();
    int unsigned n;
    int unsigned pick;
    n = $urandom_range(1, 2);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: add_char(8'h09, 1'b1, 1'b0);
        1: add_char(8'h0a, 1'b1, 1'b0);
        2: add_char(8'($urandom_range(128, 255)), 1'b1, 1'b0);
        default: add_char(" ", 1'b1, 1'b0);
      endcase
    end
  endtask

  task automatic add_number();
    int unsigned pick;
    int unsigned len;
    string lit;
    pick = $urandom_range(0, 15);
    lit = "";
    if (pick == 0) lit = "2147483647";
    else if (pick == 1) lit = "2147483648";
    if (lit.len() != 0) begin
      for (int k = 0; k < lit.len(); k++) add_char(lit[k], 1'b1, 1'b0);
    end else begin
      // mostly short numbers, now and then one long enough to clamp
      if (pick < 10) len = $urandom_range(1, 3);
      else if (pick < 15) len = $urandom_range(4, 9);
      else len = $urandom_range(10, 14);
      for (int k = 0; k < len; k++)
        add_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
    end
  endtask

  task automatic add_expression();
    int unsigned nterms;
    nterms = $urandom_range(1, 4);
    for (int t = 0; t < nterms; t++) begin
      if ($urandom_range(0, 2) == 0) add_blank();
      add_number();
      if (t < nterms - 1) begin
        if ($urandom_range(0, 2) == 0) add_blank();
        add_char(op_char($urandom_range(0, 3)), 1'b1, 1'b0);
        if ($urandom_range(0, 7) == 0) add_char(op_char($urandom_range(0, 3)), 1'b1, 1'b0);
      end
    end
    // several ways to close the text
    case ($urandom_range(0, 3))
      0: set_stop_on_last();
      1: add_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      2: add_char(op_char($urandom_range(0, 3)), 1'b1, 1'b1);
      default: add_char(" ", 1'b1, 1'b1);
    endcase
  endtask

  task automatic add_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++)
      add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 5) == 0);
  endtask

  // output side ready with random stall bursts
  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk_i);
      end
    end
  end

  // output check on every token transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_tokens.size() == 0) begin
        note_mismatch("token with none pending", 64'(m_axis_tuser_o), 64'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (m_axis_tuser_o !== want.kind)
          note_mismatch("token_kind", 64'(m_axis_tuser_o), 64'(want.kind));
        if (m_axis_tdata_o[VB-1:0] !== want.value)
          note_mismatch("number_value", 64'(m_axis_tdata_o[VB-1:0]), 64'(want.value));
        if (m_axis_tdata_o[VB] !== want.sat)
          note_mismatch("value_saturated", 64'(m_axis_tdata_o[VB]), 64'(want.sat));
        if (m_axis_tlast_o !== want.last)
          note_mismatch("run_last", 64'(m_axis_tlast_o), 64'(want.last));
        if ((m_axis_tdata_o >> (VB + 1)) !== '0)
          note_mismatch("tdata pad", 64'(m_axis_tdata_o >> (VB + 1)), 64'd0);
      end
    end
  end

  // run limit
  initial begin
    #6000000;
    $display("[arith_expression_lexer_top] ERROR");
    $finish;
  end

  // stimulus and end of run
  initial begin : main_seq
    char_item_t it;
    int unsigned base;
    int unsigned total;
    for (int k = 0; k < NDIR; k++) char_items.push_back(dir_rows[k]);
    while (char_items.size() < NDIR + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) add_noise();
      else add_expression();
    end
    total = char_items.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < total; i++) begin
      it = char_items[i];
      if (i >= total - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      s_axis_tvalid_i = 1'b1;
      s_axis_tdata_i  = it.ch;
      s_axis_tuser_i  = it.present;
      s_axis_tlast_i  = it.stop;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      // transfer taken at this edge
      base = pending_tokens.size();
      lex_char(it.ch, it.present, it.stop);
      if (it.typed) begin
        while (pending_tokens.size() > base) void'(pending_tokens.pop_back());
        if (it.has_token) begin
          emit_token(it.kind, it.value, it.sat);
          mark_last();
        end
      end
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_tokens.size() == 0) begin
      $display("[arith_expression_lexer_top] OK");
    end else begin
      $display("[arith_expression_lexer_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ael_pkg.sv
hdl/ael_front.sv
hdl/ael_queue.sv
hdl/ael_back.sv
hdl/arith_expression_lexer_top.sv
bench/tb_arith_expression_lexer_top.sv
